// ===== hdl/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size-class bump allocator: granule and
// arena geometry, action and release codes, controller states, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scba_pkg;

	// arena geometry
	localparam int GRANULE     = 8;
	localparam int GRAN_SHIFT  = $clog2(GRANULE);
	localparam int ARENA_BYTES = 1024 * 1024;

	// field and state widths
	localparam int BYTES_W = 24;
	localparam int OFFS_W  = 21;
	localparam int GRANT_W = 20;
	localparam int CLASS_W = 21;
	localparam int KIND_W  = 3;
	localparam int STATE_W = 21;
	localparam int SIZE_W  = BYTES_W + 1;
	localparam int SUM_W   = SIZE_W + 1;
	localparam int WORD_W  = 2 * STATE_W;

	localparam logic [STATE_W-1:0] STATE_MAX = '1;

	// request codes
	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// release outcome codes
	localparam logic [KIND_W-1:0] KIND_NONE       = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TOP        = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TOP_RESET  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_COUNT      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_COUNT_RESET = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/scba_ram.sv =====
// ----------------------------------------------------------------------------
// scba_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 512
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/scba_ctrl.sv =====
// ----------------------------------------------------------------------------
// scba_ctrl
// Controller: clearing sweep after reset, then one item at a time through
// read and commit.
// ----------------------------------------------------------------------------
module scba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  scba_pkg::sts_t sts,
	output scba_pkg::cmd_t cmd
);

	scba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scba_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		cmd.clr_wr  = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			scba_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = scba_pkg::ST_IDLE;
				end
			end
			scba_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = scba_pkg::ST_EXEC;
				end
			end
			scba_pkg::ST_EXEC: begin
				// hold the entry until the output register can take the item
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = scba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scba_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== hdl/scba_dp.sv =====
// ----------------------------------------------------------------------------
// scba_dp
// Datapath: request registers, arena state memory, allocate/release update,
// clear counter and output register.
// ----------------------------------------------------------------------------
module scba_dp #(
	parameter int NUM_CLASSES = 512
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  scba_pkg::cmd_t                    cmd,
	output scba_pkg::sts_t                    sts,
	input  logic                              action,
	input  logic [scba_pkg::BYTES_W-1:0]      byte_count,
	input  logic                              in_arena,
	input  logic [scba_pkg::OFFS_W-1:0]       offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [scba_pkg::GRANT_W-1:0]      granted_offset,
	output logic                              served_by_arena,
	output logic [scba_pkg::CLASS_W-1:0]      class_index,
	output logic [scba_pkg::KIND_W-1:0]       release_kind,
	output logic                              external_release
);

	localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SIZE_W = scba_pkg::SIZE_W;
	localparam int SUM_W  = scba_pkg::SUM_W;
	localparam int ST_W   = scba_pkg::STATE_W;

	// request registers
	logic                               action_q;
	logic                               in_arena_q;
	logic [scba_pkg::OFFS_W-1:0]        offset_q;
	logic [scba_pkg::CLASS_W-1:0]       class_q;
	logic [SIZE_W-1:0]                  size_q;
	logic                               in_range_q;
	logic [AW-1:0]                      clr_cnt_q;
	logic                               out_valid_q;

	logic [scba_pkg::CLASS_W-1:0]       class_in;
	logic [SIZE_W-1:0]                  size_in;

	logic                               mem_we;
	logic [AW-1:0]                      mem_waddr;
	logic [scba_pkg::WORD_W-1:0]        mem_wdata;
	logic [scba_pkg::WORD_W-1:0]        mem_rdata;

	logic [ST_W-1:0]                    bump;
	logic [ST_W-1:0]                    freed;
	logic [SUM_W-1:0]                   alloc_sum;
	logic [SUM_W-1:0]                   top_sum;
	logic [SUM_W-1:0]                   freed_sum;
	logic [ST_W-1:0]                    freed_sat;
	logic                               alloc_ok;
	logic                               rel_ext;
	logic [ST_W-1:0]                    bump_new;
	logic [ST_W-1:0]                    freed_new;
	logic [scba_pkg::GRANT_W-1:0]       grant_n;
	logic                               served_n;
	logic [scba_pkg::KIND_W-1:0]        kind_n;
	logic                               ext_n;

	// class by truncating division, size rounded up to the granule
	assign class_in = scba_pkg::CLASS_W'(byte_count >> scba_pkg::GRAN_SHIFT);
	assign size_in  = (SIZE_W'(byte_count) + SIZE_W'(scba_pkg::GRANULE - 1))
		& ~SIZE_W'(scba_pkg::GRANULE - 1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q   <= action;
			in_arena_q <= in_arena;
			offset_q   <= offset;
			class_q    <= class_in;
			size_q     <= size_in;
			in_range_q <= class_in < scba_pkg::CLASS_W'(NUM_CLASSES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign sts.clr_last = clr_cnt_q == AW'(NUM_CLASSES - 1);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign bump  = mem_rdata[2*ST_W-1:ST_W];
	assign freed = mem_rdata[ST_W-1:0];

	assign alloc_sum = SUM_W'(bump) + SUM_W'(size_q);
	assign top_sum   = SUM_W'(offset_q) + SUM_W'(size_q);
	assign freed_sum = SUM_W'(freed) + SUM_W'(size_q);
	assign freed_sat = (freed_sum > SUM_W'(scba_pkg::STATE_MAX))
		? scba_pkg::STATE_MAX : freed_sum[ST_W-1:0];

	assign alloc_ok = in_range_q && (alloc_sum < SUM_W'(scba_pkg::ARENA_BYTES));
	assign rel_ext  = !in_range_q || !in_arena_q
		|| (offset_q > scba_pkg::OFFS_W'(scba_pkg::ARENA_BYTES));

	always_comb begin
		bump_new  = bump;
		freed_new = freed;
		grant_n   = '0;
		served_n  = 1'b0;
		kind_n    = scba_pkg::KIND_NONE;
		ext_n     = 1'b0;
		if (action_q == scba_pkg::ACT_ALLOC) begin
			if (alloc_ok) begin
				grant_n  = bump[scba_pkg::GRANT_W-1:0];
				served_n = 1'b1;
				bump_new = alloc_sum[ST_W-1:0];
			end
		end else if (rel_ext) begin
			ext_n = 1'b1;
		end else if (top_sum == SUM_W'(bump)) begin
			// top block returned: bump pointer retreats
			if (offset_q == freed) begin
				bump_new  = '0;
				freed_new = '0;
				kind_n    = scba_pkg::KIND_TOP_RESET;
			end else begin
				bump_new = offset_q;
				kind_n   = scba_pkg::KIND_TOP;
			end
		end else if (freed_sat == bump) begin
			bump_new  = '0;
			freed_new = '0;
			kind_n    = scba_pkg::KIND_COUNT_RESET;
		end else begin
			freed_new = freed_sat;
			kind_n    = scba_pkg::KIND_COUNT;
		end
	end

	// the single write port serves both the clearing sweep and the commit
	assign mem_we    = cmd.clr_wr || (cmd.commit && in_range_q);
	assign mem_waddr = cmd.clr_wr ? clr_cnt_q : class_q[AW-1:0];
	assign mem_wdata = cmd.clr_wr ? '0 : {bump_new, freed_new};

	scba_ram #(
		.WIDTH (scba_pkg::WORD_W),
		.DEPTH (NUM_CLASSES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.capture),
		.raddr (class_in[AW-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			granted_offset   <= grant_n;
			served_by_arena  <= served_n;
			class_index      <= class_q;
			release_kind     <= kind_n;
			external_release <= ext_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/size_class_bump_allocator.sv =====
// ----------------------------------------------------------------------------
// size_class_bump_allocator
// Per-class bump allocator: each size class owns an arena with a bump offset
// and a freed-byte total held in one memory word; allocations bump, releases
// retreat or count, and an arena empties when the two meet.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | to block  | in_valid / in_stall  | action byte_count in_arena offset
//  out     | from block| out_valid / out_stall| granted_offset served_by_arena
//          |           |                      | class_index release_kind
//          |           |                      | external_release
//
//  each item first reads its class entry, then updates it and loads the
//  output register (memory read-modify-write turn)
//  after reset the block clears every arena memory entry to zero, with
//  in_stall high
//  a stalled output holds its item; the entry update waits until the output
//  register frees up, and no new item is taken meanwhile
// ----------------------------------------------------------------------------
module size_class_bump_allocator #(
	parameter int NUM_CLASSES = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         action,
	input  logic [scba_pkg::BYTES_W-1:0] byte_count,
	input  logic                         in_arena,
	input  logic [scba_pkg::OFFS_W-1:0]  offset,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [scba_pkg::GRANT_W-1:0] granted_offset,
	output logic                         served_by_arena,
	output logic [scba_pkg::CLASS_W-1:0] class_index,
	output logic [scba_pkg::KIND_W-1:0]  release_kind,
	output logic                         external_release
);

	scba_pkg::cmd_t cmd;
	scba_pkg::sts_t sts;

	scba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	scba_dp #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.action           (action),
		.byte_count       (byte_count),
		.in_arena         (in_arena),
		.offset           (offset),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.granted_offset   (granted_offset),
		.served_by_arena  (served_by_arena),
		.class_index      (class_index),
		.release_kind     (release_kind),
		.external_release (external_release)
	);

endmodule

// ===== hdl/scba_checker.sv =====
// ----------------------------------------------------------------------------
// scba_checker
// Port-level checks for the size-class bump allocator, bound to the top level.
// ----------------------------------------------------------------------------
module scba_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [scba_pkg::GRANT_W-1:0] granted_offset,
	input logic                         served_by_arena,
	input logic [scba_pkg::KIND_W-1:0]  release_kind,
	input logic                         external_release
);

	// one item at a time: the cycle after an accept takes nothing
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous item in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_offset)
			&& $stable(release_kind))
		else $error("stalled output item changed");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> release_kind <= scba_pkg::KIND_COUNT_RESET)
		else $error("release kind out of range");

	// an allocate result never carries release information
	a_served_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && served_by_arena |-> !external_release
			&& release_kind == scba_pkg::KIND_NONE)
		else $error("served allocation with release outcome");

	a_ext_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && external_release |-> release_kind == scba_pkg::KIND_NONE
			&& granted_offset == '0)
		else $error("external release with arena outcome");

endmodule

bind size_class_bump_allocator scba_checker u_scba_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.granted_offset   (granted_offset),
	.served_by_arena  (served_by_arena),
	.release_kind     (release_kind),
	.external_release (external_release)
);
